// ----- design/assert_macros.svh -----
// Assertion macros shared by the chunked body decoder RTL.
// Depends on nothing; simulation builds get checks, SYNTH builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- design/chbd_pkg.sv -----
// Types, constants and helper functions of the chunked body decoder.
// Used by chbd_step and http_chunked_body_decoder; depends on nothing.
package chbd_pkg;

    localparam int SIZE_BITS = 32;
    localparam int PHASE_W   = 4;

    // framing phases
    localparam logic [PHASE_W-1:0] PH_SIZE_FIRST = 4'd0;
    localparam logic [PHASE_W-1:0] PH_SIZE       = 4'd1;
    localparam logic [PHASE_W-1:0] PH_EXT        = 4'd2;
    localparam logic [PHASE_W-1:0] PH_SIZE_LF    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_BODY       = 4'd4;
    localparam logic [PHASE_W-1:0] PH_END_CR     = 4'd5;
    localparam logic [PHASE_W-1:0] PH_END_LF     = 4'd6;
    localparam logic [PHASE_W-1:0] PH_TRL_CR     = 4'd7;
    localparam logic [PHASE_W-1:0] PH_TRL_LF     = 4'd8;

    // result status
    localparam logic [1:0] ST_BODY  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NO_HEX     = 3'd0;
    localparam logic [2:0] ERR_NO_SIZE_LF = 3'd1;
    localparam logic [2:0] ERR_TRAILER    = 3'd2;
    localparam logic [2:0] ERR_CHUNK_END  = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW   = 3'd4;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;

    typedef logic [SIZE_BITS-1:0] size_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] body_byte;
        logic       chunk_last;
        logic [2:0] error_code;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    // Decode one ASCII hex digit, either case.
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.value = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            h.value = c[3:0] + 4'd9;
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ----- design/chbd_step.sv -----
// Combinational framing step of the chunked body decoder: one byte in,
// next phase, next counter and an optional result out. Depends on chbd_pkg.
module chbd_step (
    input  logic [chbd_pkg::PHASE_W-1:0] phase,
    input  chbd_pkg::size_t              remaining,
    input  logic [7:0]                   rx_byte,
    output logic [chbd_pkg::PHASE_W-1:0] phase_next,
    output chbd_pkg::size_t              remaining_next,
    output logic                         res_valid,
    output chbd_pkg::result_t            res
);

    chbd_pkg::hex_t hex;
    logic           is_cr;
    logic           is_lf;
    logic           size_full;
    logic           err;
    logic [2:0]     err_code;

    assign hex       = chbd_pkg::hex_decode(rx_byte);
    assign is_cr     = (rx_byte == chbd_pkg::CH_CR);
    assign is_lf     = (rx_byte == chbd_pkg::CH_LF);
    assign size_full = (remaining[chbd_pkg::SIZE_BITS-1 -: 4] != 4'd0);

    // Advance the framing state for one byte
    always_comb
    begin
        phase_next     = phase;
        remaining_next = remaining;
        res_valid      = 1'b0;
        res            = '0;
        err            = 1'b0;
        err_code       = chbd_pkg::ERR_NO_HEX;
        unique case (phase)
            chbd_pkg::PH_SIZE:
            begin
                if (hex.ok)
                begin
                    if (size_full)
                    begin
                        err      = 1'b1;
                        err_code = chbd_pkg::ERR_OVERFLOW;
                    end
                    else
                    begin
                        remaining_next = {remaining[chbd_pkg::SIZE_BITS-5:0], hex.value};
                    end
                end
                else if (is_cr)
                begin
                    phase_next = chbd_pkg::PH_SIZE_LF;
                end
                else
                begin
                    phase_next = chbd_pkg::PH_EXT;
                end
            end
            chbd_pkg::PH_EXT:
            begin
                if (is_cr)
                begin
                    phase_next = chbd_pkg::PH_SIZE_LF;
                end
            end
            chbd_pkg::PH_SIZE_LF:
            begin
                if (!is_lf)
                begin
                    err      = 1'b1;
                    err_code = chbd_pkg::ERR_NO_SIZE_LF;
                end
                else if (remaining == '0)
                begin
                    phase_next = chbd_pkg::PH_TRL_CR;
                end
                else
                begin
                    phase_next = chbd_pkg::PH_BODY;
                end
            end
            chbd_pkg::PH_BODY:
            begin
                res_valid      = 1'b1;
                res.status     = chbd_pkg::ST_BODY;
                res.body_byte  = rx_byte;
                res.chunk_last = (remaining <= chbd_pkg::size_t'(1));
                if (remaining != '0)
                begin
                    remaining_next = remaining - chbd_pkg::size_t'(1);
                end
                if (res.chunk_last)
                begin
                    phase_next = chbd_pkg::PH_END_CR;
                end
            end
            chbd_pkg::PH_END_CR:
            begin
                if (!is_cr)
                begin
                    err      = 1'b1;
                    err_code = chbd_pkg::ERR_CHUNK_END;
                end
                else
                begin
                    phase_next = chbd_pkg::PH_END_LF;
                end
            end
            chbd_pkg::PH_END_LF:
            begin
                if (!is_lf)
                begin
                    err      = 1'b1;
                    err_code = chbd_pkg::ERR_CHUNK_END;
                end
                else
                begin
                    phase_next     = chbd_pkg::PH_SIZE_FIRST;
                    remaining_next = '0;
                end
            end
            chbd_pkg::PH_TRL_CR:
            begin
                if (!is_cr)
                begin
                    err      = 1'b1;
                    err_code = chbd_pkg::ERR_TRAILER;
                end
                else
                begin
                    phase_next = chbd_pkg::PH_TRL_LF;
                end
            end
            chbd_pkg::PH_TRL_LF:
            begin
                if (!is_lf)
                begin
                    err      = 1'b1;
                    err_code = chbd_pkg::ERR_TRAILER;
                end
                else
                begin
                    phase_next     = chbd_pkg::PH_SIZE_FIRST;
                    remaining_next = '0;
                    res_valid      = 1'b1;
                    res.status     = chbd_pkg::ST_DONE;
                end
            end
            default:
            begin
                // first size digit; unused codes land here too
                if (!hex.ok)
                begin
                    err      = 1'b1;
                    err_code = chbd_pkg::ERR_NO_HEX;
                end
                else
                begin
                    remaining_next = chbd_pkg::size_t'(hex.value);
                    phase_next     = chbd_pkg::PH_SIZE;
                end
            end
        endcase

        // Drop back to a fresh size on any framing fault or size overflow
        if (err)
        begin
            phase_next     = chbd_pkg::PH_SIZE_FIRST;
            remaining_next = '0;
            res_valid      = 1'b1;
            res            = '0;
            res.status     = chbd_pkg::ST_ERROR;
            res.error_code = err_code;
        end
    end

endmodule

// ----- design/http_chunked_body_decoder.sv -----
// Top level of the HTTP chunked body decoder: input register, framing step,
// result register. Depends on chbd_pkg, chbd_step and assert_macros.svh.
//
// Usage: feed the chunked body one byte per transaction on the input channel
// (in_valid, in_ready, rx_byte). Size digits, extensions and CR/LF framing
// give no result. Each body byte gives one result on the output channel
// (out_valid, out_ready) with status body, the byte and chunk_last on the
// final byte of its chunk. The empty trailer after a zero-size chunk gives a
// single message-complete result; a framing fault or a size too wide for the
// counter gives one error result with its code, after which a new size is
// expected.
// Each accepted byte waits in the input register, and its result is loaded
// into the result register when the framing step processes it. Throughput:
// one byte per cycle while the receiver takes results, set by the
// combinational framing step between the two registers.
// Reset empties both registers and starts in the first-size-digit phase.
// When the receiver stalls, the result register holds its transaction and
// one more byte waits in the input register; in_ready then drops until the
// result is taken. Bytes that give no result still move on during a stall.
`include "assert_macros.svh"

module http_chunked_body_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [7:0] body_byte,
    output logic       chunk_last,
    output logic [2:0] error_code
);

    logic                         in_valid_reg;
    logic [7:0]                   byte_reg;
    logic [chbd_pkg::PHASE_W-1:0] phase_reg;
    logic [chbd_pkg::PHASE_W-1:0] phase_next;
    chbd_pkg::size_t              remaining_reg;
    chbd_pkg::size_t              remaining_next;
    logic                         out_valid_reg;
    chbd_pkg::result_t            result_reg;
    logic                         res_valid;
    chbd_pkg::result_t            res;
    logic                         out_space;
    logic                         fire;

    chbd_step u_step (
        .phase          (phase_reg),
        .remaining      (remaining_reg),
        .rx_byte        (byte_reg),
        .phase_next     (phase_next),
        .remaining_next (remaining_next),
        .res_valid      (res_valid),
        .res            (res)
    );

    // Process the held byte when the result register can take its output or it gives none
    assign out_space = !out_valid_reg || out_ready;
    assign fire      = in_valid_reg && (out_space || !res_valid);
    assign in_ready  = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= rx_byte;
        end
    end

    // Framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= chbd_pkg::PH_SIZE_FIRST;
            remaining_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_space)
        begin
            out_valid_reg <= fire && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            result_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = result_reg.status;
    assign body_byte  = result_reg.body_byte;
    assign chunk_last = result_reg.chunk_last;
    assign error_code = result_reg.error_code;

    `ASSERT_IMPL(a_body_nonzero, clk, rst_n, phase_reg == chbd_pkg::PH_BODY, remaining_reg != '0)
    `ASSERT_IMPL(a_first_clear, clk, rst_n, phase_reg == chbd_pkg::PH_SIZE_FIRST, remaining_reg == '0)
    `ASSERT_NEXT(a_last_end, clk, rst_n, fire && res_valid && res.chunk_last, phase_reg == chbd_pkg::PH_END_CR)
    `ASSERT_IMPL(a_nonbody_clean, clk, rst_n, out_valid_reg && status != chbd_pkg::ST_BODY, !chunk_last && body_byte == 8'd0)
    `ASSERT_NEXT(a_byte_held, clk, rst_n, in_valid_reg && !fire, in_valid_reg && $stable(byte_reg))

endmodule
